FILE: design/rstab_pkg.sv
// ----------------------------------------------------------------------------
// rstab_pkg
// Types and constants shared by the randomized set table modules.
// ----------------------------------------------------------------------------
package rstab_pkg;

    localparam int CAPACITY   = 64;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int DATA_W     = 32;
    localparam int DRAW_W     = 16;
    localparam int DRAW_CNT_W = $clog2(DRAW_W);
    localparam int SETCNT_W   = 7;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_RANDOM = 2'd2;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_NOHIT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic [1:0]               func;
        logic signed [DATA_W-1:0] item_value;
        logic [DRAW_W-1:0]        random_draw;
    } t_in_item;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] element;
        logic [SETCNT_W-1:0]      set_count;
    } t_out_item;

endpackage

FILE: design/rstab_ram.sv
// ----------------------------------------------------------------------------
// rstab_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module rstab_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/rstab_mod.sv
// ----------------------------------------------------------------------------
// rstab_mod
// Bit-serial restoring remainder unit: draw modulo count, one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
module rstab_mod (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [rstab_pkg::DRAW_W-1:0]        i_dividend,
    input  logic [rstab_pkg::CNT_W-1:0]         i_divisor,
    output logic                                o_done,
    output logic [rstab_pkg::CNT_W-1:0]         o_rem
);
    import rstab_pkg::*;

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [DRAW_CNT_W-1:0] r_cnt, n_cnt;
    logic [DRAW_W-1:0]     r_dvd, n_dvd;
    logic [CNT_W-1:0]      r_div, n_div;
    logic [CNT_W-1:0]      r_rem, n_rem;
    logic [CNT_W:0]        w_trial;
    logic [CNT_W:0]        w_diff;

    always_comb begin
        w_trial = {r_rem, r_dvd[DRAW_W-1]};
        w_diff  = w_trial - {1'b0, r_div};
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_dvd   = r_dvd;
        n_div   = r_div;
        n_rem   = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_dvd  = i_dividend;
            n_div  = i_divisor;
            n_rem  = '0;
        end else if (r_busy) begin
            // The partial remainder stays below the divisor, so it fits CNT_W bits.
            if (w_trial >= {1'b0, r_div}) begin
                n_rem = w_diff[CNT_W-1:0];
            end else begin
                n_rem = w_trial[CNT_W-1:0];
            end
            n_dvd = {r_dvd[DRAW_W-2:0], 1'b0};
            n_cnt = r_cnt + DRAW_CNT_W'(1);
            if (r_cnt == DRAW_CNT_W'(DRAW_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_dvd <= n_dvd;
        r_div <= n_div;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_div))
        else $error("remainder not below divisor");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("done while still iterating");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("start while busy");

endmodule

FILE: design/randomized_set_table_unit.sv
// ----------------------------------------------------------------------------
// randomized_set_table_unit
// Set of 32-bit values held densely in one RAM with a count register.
// ----------------------------------------------------------------------------
// Insert and remove scan the held entries one RAM read per cycle.
// Get random waits on the bit-serial remainder unit, then reads the drawn entry.
// One item is processed at a time; the next is taken after its result is queued.
// Reset clears the count and control state; the RAM is not cleared.
module randomized_set_table_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  rstab_pkg::t_in_item   i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output rstab_pkg::t_out_item  o_out_item
);
    import rstab_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_RM_RD,
        S_RM_WR,
        S_MOD,
        S_RD_WAIT,
        S_RESP
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [1:0]       r_op, n_op;
    logic [DATA_W-1:0] r_val, n_val;
    logic [CNT_W-1:0] r_issue, n_issue;
    logic             r_pend, n_pend;
    logic [IDX_W-1:0] r_pend_idx, n_pend_idx;
    logic [IDX_W-1:0] r_hit, n_hit;
    logic [1:0]       r_status, n_status;
    logic [DATA_W-1:0] r_elem, n_elem;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out_item, n_out_item;

    logic              w_accept;
    logic              w_we, w_re;
    logic [IDX_W-1:0]  w_waddr, w_raddr;
    logic [DATA_W-1:0] w_wdata, w_rdata;
    logic [CNT_W-1:0]  w_last;
    logic              w_mod_start, w_mod_done;
    logic [CNT_W-1:0]  w_mod_rem;

    assign w_accept    = i_in_valid && o_in_ready;
    assign w_last      = r_count - CNT_W'(1);
    assign w_mod_start = w_accept && (i_in_item.func == FUNC_RANDOM) && (r_count != '0);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_op        = r_op;
        n_val       = r_val;
        n_issue     = r_issue;
        n_pend      = r_pend;
        n_pend_idx  = r_pend_idx;
        n_hit       = r_hit;
        n_status    = r_status;
        n_elem      = r_elem;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_item  = r_out_item;
        w_we        = 1'b0;
        w_waddr     = r_count[IDX_W-1:0];
        w_wdata     = r_val;
        w_re        = 1'b0;
        w_raddr     = r_issue[IDX_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op     = i_in_item.func;
                    n_val    = i_in_item.item_value;
                    n_issue  = '0;
                    n_pend   = 1'b0;
                    n_status = ST_DONE;
                    n_elem   = '0;
                    case (i_in_item.func)
                        FUNC_INSERT, FUNC_REMOVE: n_state = S_SCAN;
                        FUNC_RANDOM: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_RESP;
                            end else begin
                                n_state = S_MOD;
                            end
                        end
                        default: n_state = S_RESP;
                    endcase
                end
            end
            S_SCAN: begin
                // Reads are issued one per cycle; each compare sees the data
                // of the read issued the cycle before.
                if (r_pend && (w_rdata == r_val)) begin
                    if (r_op == FUNC_INSERT) begin
                        n_status = ST_NOHIT;
                        n_state  = S_RESP;
                    end else begin
                        n_hit   = r_pend_idx;
                        n_state = S_RM_RD;
                    end
                end else if (!r_pend && (r_issue >= r_count)) begin
                    if (r_op == FUNC_REMOVE) begin
                        n_status = ST_NOHIT;
                    end else if (r_count >= CNT_W'(CAPACITY)) begin
                        n_status = ST_FULL;
                    end else begin
                        w_we    = 1'b1;
                        n_count = r_count + CNT_W'(1);
                    end
                    n_state = S_RESP;
                end else begin
                    w_re       = (r_issue < r_count);
                    n_pend     = (r_issue < r_count);
                    n_pend_idx = r_issue[IDX_W-1:0];
                    if (r_issue < r_count) begin
                        n_issue = r_issue + CNT_W'(1);
                    end
                end
            end
            S_RM_RD: begin
                w_re    = 1'b1;
                w_raddr = w_last[IDX_W-1:0];
                n_state = S_RM_WR;
            end
            S_RM_WR: begin
                // Move the last held entry into the freed slot.
                w_we    = 1'b1;
                w_waddr = r_hit;
                w_wdata = w_rdata;
                n_count = w_last;
                n_state = S_RESP;
            end
            S_MOD: begin
                if (w_mod_done) begin
                    w_re    = 1'b1;
                    w_raddr = w_mod_rem[IDX_W-1:0];
                    n_state = S_RD_WAIT;
                end
            end
            S_RD_WAIT: begin
                n_elem  = w_rdata;
                n_state = S_RESP;
            end
            S_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid          = 1'b1;
                    n_out_item.status    = r_status;
                    n_out_item.element   = r_elem;
                    n_out_item.set_count = SETCNT_W'(r_count);
                    n_state              = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_op       <= n_op;
        r_val      <= n_val;
        r_issue    <= n_issue;
        r_pend_idx <= n_pend_idx;
        r_hit      <= n_hit;
        r_status   <= n_status;
        r_elem     <= n_elem;
        r_out_item <= n_out_item;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    rstab_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    rstab_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (i_in_item.random_draw),
        .i_divisor  (r_count),
        .o_done     (w_mod_done),
        .o_rem      (w_mod_rem)
    );

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("count above capacity");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_in_ready)
        else $error("second item taken while one is in progress");

    a_count_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_MOD || r_state == S_RESP) |=>
        (r_count == $past(r_count)))
        else $error("count changed outside an update state");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status == ST_EMPTY) |-> (o_out_item.set_count == '0))
        else $error("empty status with nonzero count");

endmodule
